/* rtl/core/bpcm_pkg.sv */
package bpcm_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam int unsigned PinBitsDef   = 16;

  localparam int unsigned CfgW   = 5;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned FileW  = 8;
  localparam int unsigned PageW  = 32;
  localparam int unsigned FrameW = 4;
  localparam int unsigned StatW  = 3;

  localparam logic [ReqW-1:0] ReqRead    = 3'd0;
  localparam logic [ReqW-1:0] ReqUnpin   = 3'd1;
  localparam logic [ReqW-1:0] ReqAlloc   = 3'd2;
  localparam logic [ReqW-1:0] ReqDispose = 3'd3;
  localparam logic [ReqW-1:0] ReqFlush   = 3'd4;

  localparam logic [StatW-1:0] StHit    = 3'd0;
  localparam logic [StatW-1:0] StLoad   = 3'd1;
  localparam logic [StatW-1:0] StDone   = 3'd2;
  localparam logic [StatW-1:0] StAllPin = 3'd3;
  localparam logic [StatW-1:0] StNotPin = 3'd4;
  localparam logic [StatW-1:0] StPinned = 3'd5;

  typedef enum logic [2:0] {
    OpNone,
    OpLatch,
    OpPin,
    OpUnpin,
    OpClear,
    OpSetFrame,
    OpSweepStep,
    OpFlushStep
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       emit;
    logic       emit_last;
    logic [StatW-1:0] emit_status;
    logic       emit_use_hit;
    logic       emit_wb;
    logic       emit_cur;
    logic       cnt_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic       hit;
    logic       hit_pinned;
    logic       any_free;
    logic       cur_valid;
    logic       cur_ref;
    logic       cur_pinned;
    logic       cur_dirty;
    logic       cur_match;
    logic       cnt_end;
  } dp_stat_t;

endpackage

/* rtl/core/bpcm_ctrl.sv */
module bpcm_ctrl
  import bpcm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    SIdle,
    SLook,
    SSweep,
    SFlush,
    SFlushDone,
    SAssign
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OpNone, emit_status: StDone, default: '0};
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.op = OpLatch;
          state_d  = SLook;
        end
      end
      SLook: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        state_d         = SIdle;
        case (stat_i.req)
          ReqRead, ReqAlloc: begin
            if (stat_i.hit) begin
              cmd_o.op           = OpPin;
              cmd_o.emit_status  = StHit;
              cmd_o.emit_use_hit = 1'b1;
            end else if (!stat_i.any_free) begin
              cmd_o.emit_status = StAllPin;
            end else begin
              cmd_o.emit = 1'b0;
              state_d    = SSweep;
            end
          end
          ReqUnpin: begin
            if (stat_i.hit) begin
              cmd_o.emit_use_hit = 1'b1;
              if (stat_i.hit_pinned) begin
                cmd_o.op = OpUnpin;
              end else begin
                cmd_o.emit_status = StNotPin;
              end
            end
          end
          ReqDispose: begin
            if (stat_i.hit) begin
              cmd_o.emit_use_hit = 1'b1;
              if (stat_i.hit_pinned) begin
                cmd_o.emit_status = StPinned;
              end else begin
                cmd_o.op = OpClear;
              end
            end
          end
          ReqFlush: begin
            cmd_o.emit = 1'b0;
            state_d    = SFlush;
          end
          default: ;
        endcase
      end
      SSweep: begin
        cmd_o.op = OpSweepStep;
        if (!stat_i.cur_valid) begin
          state_d = SAssign;
        end else if (!stat_i.cur_ref && !stat_i.cur_pinned) begin
          cmd_o.emit     = stat_i.cur_dirty;
          cmd_o.emit_wb  = 1'b1;
          cmd_o.emit_cur = 1'b1;
          state_d        = SAssign;
        end else if (stat_i.cnt_end) begin
          state_d = SAssign;
        end
      end
      SAssign: begin
        cmd_o.op          = OpSetFrame;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_last   = 1'b1;
        cmd_o.emit_cur    = 1'b1;
        cmd_o.emit_status = (stat_i.req == ReqRead) ? StLoad : StDone;
        state_d           = SIdle;
      end
      SFlush: begin
        if (stat_i.cur_match && stat_i.cur_pinned) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_cur    = 1'b1;
          cmd_o.emit_status = StPinned;
          state_d           = SIdle;
        end else begin
          cmd_o.op       = OpFlushStep;
          cmd_o.emit     = stat_i.cur_match && stat_i.cur_dirty;
          cmd_o.emit_wb  = 1'b1;
          cmd_o.emit_cur = 1'b1;
          if (stat_i.cnt_end) state_d = SFlushDone;
        end
      end
      SFlushDone: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
        state_d         = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bpcm_dp.sv */
module bpcm_dp
  import bpcm_pkg::*;
#(
  parameter int unsigned MaxFrames = MaxFramesDef,
  parameter int unsigned PinBits   = PinBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [FileW-1:0]  file_id_i,
  input  logic [PageW-1:0]  page_no_i,
  input  logic              mark_dirty_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic              res_valid_o,
  output logic [FrameW-1:0] frame_no_o,
  output logic [StatW-1:0]  status_o,
  output logic              is_writeback_o,
  output logic [FileW-1:0]  wb_file_id_o,
  output logic [PageW-1:0]  wb_page_no_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned CntW = $clog2(2 * MaxFrames + 2);
  localparam logic [PinBits-1:0] PinTop = '1;

  logic [CfgW-1:0]    nf_q;
  logic [IdxW:0]      n_act;
  logic [IdxW-1:0]    hand_q, cur_q, hit_idx;
  logic [CntW-1:0]    cnt_q;
  logic [MaxFrames-1:0] vld_q, ref_q, dty_q;
  logic [PinBits-1:0] pins_q [MaxFrames];
  logic [FileW-1:0]   file_q [MaxFrames];
  logic [PageW-1:0]   page_q [MaxFrames];
  logic [ReqW-1:0]    req_q;
  logic [FileW-1:0]   rfile_q;
  logic [PageW-1:0]   rpage_q;
  logic               md_q, hit;
  logic               any_free;
  logic [IdxW-1:0]    nxt_hand;
  logic [IdxW:0]      hand_inc;

  always_comb begin
    if (nf_q == '0) begin
      n_act = (IdxW+1)'(1);
    end else if (32'(nf_q) > MaxFrames) begin
      n_act = (IdxW+1)'(MaxFrames);
    end else begin
      n_act = (IdxW+1)'(nf_q);
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if ((IdxW+1)'(i) < n_act) begin
        if (pins_q[i] == '0) any_free = 1'b1;
        if (vld_q[i] && file_q[i] == rfile_q && page_q[i] == rpage_q) begin
          hit     = 1'b1;
          hit_idx = IdxW'(i);
        end
      end
    end
  end

  assign hand_inc = (IdxW+1)'(hand_q) + 1'b1;
  assign nxt_hand = (hand_inc >= n_act) ? '0 : hand_inc[IdxW-1:0];

  assign stat_o.req        = req_q;
  assign stat_o.hit        = hit;
  assign stat_o.hit_pinned = pins_q[hit_idx] != '0;
  assign stat_o.any_free   = any_free;
  assign stat_o.cur_valid  = vld_q[cur_q];
  assign stat_o.cur_ref    = ref_q[cur_q];
  assign stat_o.cur_pinned = pins_q[cur_q] != '0;
  assign stat_o.cur_dirty  = dty_q[cur_q];
  assign stat_o.cur_match  = vld_q[cur_q] && file_q[cur_q] == rfile_q
                             && (IdxW+1)'(cur_q) < n_act;
  assign stat_o.cnt_end    = (req_q == ReqFlush)
                             ? ((IdxW+1)'(cur_q) + 1'b1 >= n_act)
                             : (cnt_q >= CntW'(2 * n_act));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpLatch) begin
      req_q   <= req_type_i;
      rfile_q <= file_id_i;
      rpage_q <= page_no_i;
      md_q    <= mark_dirty_i;
    end
    if (cmd_i.op == OpSetFrame) begin
      file_q[hand_q] <= rfile_q;
      page_q[hand_q] <= rpage_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q   <= CfgW'(MaxFramesDef);
      hand_q <= IdxW'(MaxFrames - 1);
      cur_q  <= '0;
      cnt_q  <= '0;
      vld_q  <= '0;
      ref_q  <= '0;
      dty_q  <= '0;
      for (int i = 0; i < MaxFrames; i++) pins_q[i] <= '0;
    end else begin
      if (cfg_valid_i) nf_q <= cfg_data_i;
      case (cmd_i.op)
        OpLatch: begin
          cur_q <= '0;
        end
        OpPin: begin
          ref_q[hit_idx] <= 1'b1;
          if (pins_q[hit_idx] != PinTop) pins_q[hit_idx] <= pins_q[hit_idx] + 1'b1;
        end
        OpUnpin: begin
          pins_q[hit_idx] <= pins_q[hit_idx] - 1'b1;
          if (md_q) dty_q[hit_idx] <= 1'b1;
        end
        OpClear: begin
          vld_q[hit_idx]  <= 1'b0;
          ref_q[hit_idx]  <= 1'b0;
          dty_q[hit_idx]  <= 1'b0;
          pins_q[hit_idx] <= '0;
        end
        OpSweepStep: begin
          if (vld_q[cur_q] && ref_q[cur_q]) ref_q[cur_q] <= 1'b0;
          hand_q <= cur_q;
          cur_q  <= (((IdxW+1)'(cur_q) + 1'b1) >= n_act) ? '0 : cur_q + 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end
        OpSetFrame: begin
          vld_q[hand_q]  <= 1'b1;
          ref_q[hand_q]  <= 1'b1;
          dty_q[hand_q]  <= 1'b0;
          pins_q[hand_q] <= PinBits'(1);
        end
        OpFlushStep: begin
          if (stat_o.cur_match) begin
            vld_q[cur_q]  <= 1'b0;
            ref_q[cur_q]  <= 1'b0;
            dty_q[cur_q]  <= 1'b0;
            pins_q[cur_q] <= '0;
          end
          cur_q <= cur_q + 1'b1;
        end
        default: ;
      endcase
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
        cur_q <= (req_q == ReqFlush) ? '0 : nxt_hand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      frame_no_o     <= '0;
      status_o       <= cmd_i.emit_status;
      is_writeback_o <= 1'b0;
      wb_file_id_o   <= '0;
      wb_page_no_o   <= '0;
      last_o         <= cmd_i.emit_last;
      if (cmd_i.emit_use_hit) frame_no_o <= FrameW'(hit_idx);
      if (cmd_i.emit_cur) begin
        frame_no_o <= (cmd_i.op == OpSetFrame) ? FrameW'(hand_q) : FrameW'(cur_q);
      end
      if (cmd_i.emit_wb && !cmd_i.emit_last) begin
        is_writeback_o <= 1'b1;
        status_o       <= StDone;
        wb_file_id_o   <= file_q[cur_q];
        wb_page_no_o   <= page_q[cur_q];
      end
    end
  end

  a_wb_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && is_writeback_o |-> !last_o) else $error("writeback marked last");
  a_setframe_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpSetFrame |=> vld_q[$past(hand_q)]) else $error("frame not set");
  a_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !res_valid_o) else $error("result after last");

endmodule

/* rtl/core/buffer_pool_clock_manager_top.sv */
// Channel  | Ports                                          | Handshake
// request  | req_type_i file_id_i page_no_i mark_dirty_i    | start & !busy
// result   | frame_no_o status_o is_writeback_o wb_*_o last_o | done_o strobe
// config   | cfg_data_i (num_frames)                        | cfg_valid_i & cfg_ready_o
// After the accepting edge busy stays high while the request is handled: for hits
// and errors, for a miss while the clock sweep steps over frames, and for a flush;
// each result is registered and appears in the cycle after the step that makes it.
// Results cannot be stalled. Reset clears the valid, reference, dirty and pin state
// of every frame and puts the hand on MaxFrames minus one.
module buffer_pool_clock_manager_top
  import bpcm_pkg::*;
#(
  parameter int unsigned MaxFrames = MaxFramesDef,
  parameter int unsigned PinBits   = PinBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [FileW-1:0]  file_id_i,
  input  logic [PageW-1:0]  page_no_i,
  input  logic              mark_dirty_i,
  output logic              done_o,
  output logic [FrameW-1:0] frame_no_o,
  output logic [StatW-1:0]  status_o,
  output logic              is_writeback_o,
  output logic [FileW-1:0]  wb_file_id_o,
  output logic [PageW-1:0]  wb_page_no_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bpcm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bpcm_dp #(.MaxFrames(MaxFrames), .PinBits(PinBits)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .file_id_i     (file_id_i),
    .page_no_i     (page_no_i),
    .mark_dirty_i  (mark_dirty_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .res_valid_o   (done_o),
    .frame_no_o    (frame_no_o),
    .status_o      (status_o),
    .is_writeback_o(is_writeback_o),
    .wb_file_id_o  (wb_file_id_o),
    .wb_page_no_o  (wb_page_no_o),
    .last_o        (last_o)
  );

endmodule
